### hdl/dks_pkg.sv
package dks_pkg;

    // Sizes
    localparam int DIGIT_SLOTS_DEF = 11;
    localparam int VALUE_W         = 32;
    localparam int DIGIT_W         = 4;
    localparam int POS_W           = 4;
    localparam int CNT_W           = 5;
    localparam int KEY_W           = 8;
    localparam int CFG_W           = 8;
    localparam int OP_W            = 1;

    // Reset value of the digit count register
    localparam logic [CFG_W-1:0] DIGIT_COUNT_RST = 8'd6;

    // Operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_POLL = 1'b1;

    // Keyboard usages
    localparam logic [KEY_W-1:0] KEY_RELEASE = 8'h00;
    localparam logic [KEY_W-1:0] KEY_ZERO    = 8'h27;
    localparam logic [KEY_W-1:0] KEY_ONE     = 8'h1E;

    typedef enum logic {
        ST_IDLE,
        ST_CONV
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;   // load item taken: capture value, clear digits
        logic step;    // one shift-and-adjust iteration
        logic finish;  // set read and end positions
        logic poll;    // poll item taken
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_step;    // final conversion iteration
        logic out_blocked;  // result held and not taken this cycle
    } t_sts;

    // Digit to key usage: '0' sits after '9'
    function automatic logic [KEY_W-1:0] usage_of_digit(input logic [DIGIT_W-1:0] d);
        logic [KEY_W-1:0] u;
        if (d == '0) begin
            u = KEY_ZERO;
        end else begin
            u = KEY_ONE + KEY_W'(d) - KEY_W'(1);
        end
        return u;
    endfunction

endpackage

### hdl/dks_ctrl.sv
module dks_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [dks_pkg::OP_W-1:0] i_op,
    input  dks_pkg::t_sts           i_sts,
    output dks_pkg::t_cmd           o_cmd
);
    import dks_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        accept          = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = !i_sts.out_blocked;
                accept          = i_s_axis_tvalid && !i_sts.out_blocked;
                if (accept) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_CONV;
                    end else begin
                        o_cmd.poll = 1'b1;
                    end
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/dks_dp.sv
module dks_dp #(
    parameter int DIGIT_SLOTS = dks_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dks_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [dks_pkg::VALUE_W-1:0] i_value,
    input  dks_pkg::t_cmd               i_cmd,
    output dks_pkg::t_sts               o_sts,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [dks_pkg::KEY_W-1:0]   o_m_axis_tdata
);
    import dks_pkg::*;

    localparam int BCD_W = DIGIT_SLOTS * DIGIT_W;

    logic [CFG_W-1:0]   r_digit_count;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [CNT_W-1:0]   r_cnt;
    logic [POS_W-1:0]   r_read;
    logic [POS_W-1:0]   r_end;
    logic               r_held;
    logic               r_out_valid;
    logic [KEY_W-1:0]   r_out_data;
    logic [POS_W-1:0]   n_count;
    logic [DIGIT_W-1:0] cur_digit;
    logic               have_work;

    // Digit count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= DIGIT_COUNT_RST;
        end else if (i_cfg_we) begin
            r_digit_count <= i_cfg_wdata;
        end
    end

    // Add 3 to every digit of 5 or more, then shift in the next binary bit.
    // Digit k (from the least significant) sits in slot DIGIT_SLOTS-1-k.
    always_comb begin
        logic [BCD_W-1:0] adj;
        adj = r_bcd;
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            if (r_bcd[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
        end
        n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
    end

    // Binary to decimal conversion
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_sts.last_step   = (r_cnt == CNT_W'(VALUE_W - 1));
    assign o_sts.out_blocked = r_out_valid && !i_m_axis_tready;

    // Saturated digit count
    assign n_count = (r_digit_count > CFG_W'(DIGIT_SLOTS)) ? POS_W'(DIGIT_SLOTS)
                                                          : r_digit_count[POS_W-1:0];

    // Digit at the read position
    always_comb begin
        cur_digit = '0;
        for (int s = 0; s < DIGIT_SLOTS; s++) begin
            if (r_read == POS_W'(s)) begin
                cur_digit = r_bcd[(DIGIT_SLOTS-1-s)*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign have_work = (r_read != r_end);

    // Read position, held key and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read      <= '0;
            r_end       <= '0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_read <= POS_W'(DIGIT_SLOTS) - n_count;
                r_end  <= POS_W'(DIGIT_SLOTS);
            end
            if (i_cmd.poll && have_work) begin
                r_out_valid <= 1'b1;
                if (r_held) begin
                    r_held <= 1'b0;
                    r_read <= r_read + POS_W'(1);
                end else begin
                    r_held <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.poll && have_work) begin
            r_out_data <= r_held ? KEY_RELEASE : usage_of_digit(cur_digit);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### hdl/decimal_keystroke_sender.sv
// Load item: 32 shift-and-adjust steps, one per value bit, run before the next item can be taken.
// Poll item: the report is registered and shown the next cycle.
// A load yields no item; a poll yields at most one.
// Synchronous active-low reset: nothing to send, no key held, digit count 6.
module decimal_keystroke_sender #(
    parameter int DIGIT_SLOTS = dks_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: digit_count
    input  logic                        i_cfg_we,
    input  logic [dks_pkg::CFG_W-1:0]   i_cfg_wdata,
    // Input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [dks_pkg::VALUE_W-1:0] i_s_axis_tdata,  // [31:0] value
    input  logic [dks_pkg::OP_W-1:0]    i_s_axis_tuser,  // [0] op
    // Output stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [dks_pkg::KEY_W-1:0]   o_m_axis_tdata   // [7:0] key_usage
);
    import dks_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dks_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_op            (i_s_axis_tuser),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    dks_dp #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_value         (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
